// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen on a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/wosc_pkg.sv
`default_nettype none
package wosc_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_PHASE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Register addresses (word index)
  localparam logic [1:0] REG_LOG2 = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_RDY  = 2'd2;

  localparam int FRAC_BITS = 23;
  localparam logic signed [23:0] COEF_B0 = 24'sd253041;
  localparam logic signed [23:0] COEF_B1 = 24'sd506081;
  localparam logic signed [23:0] COEF_A1 = 24'sd4850713;
  localparam logic signed [23:0] COEF_A2 = 24'sd1668565;

  // Saturate a wide signed value to 28 bits
  function automatic logic signed [27:0] sat28(input logic signed [63:0] v);
    if (v > 64'sd134217727) begin
      sat28 = 28'sh7ffffff;
    end else if (v < -64'sd134217728) begin
      sat28 = 28'sh8000000;
    end else begin
      sat28 = v[27:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/wavetable_osc_hermite_oversampled.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i/in_stall_o   | cmd, frequency, table_index, table_value,
//         |           |                         | phase_value
// out     | output    | out_valid_o/out_stall_i | sample
// cfg     | input     | APB write/read          | log2_points, step_scale, table_ready
// A sample command first computes the phase step; then, for each of four subsamples,
// it reads four table entries, runs three Horner products and five filter products,
// updates filter and phase and addresses the next; all products share one multiplier.
// A sample command with the table not ready gives a zero result on the next cycle.
// Write and phase commands complete on acceptance; reset clears state, not the table.
// The input stalls while a command is in flight or a result waits to leave.
`default_nettype none
module wavetable_osc_hermite_oversampled #(
  parameter int MAX_LOG2_POINTS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic signed [23:0] frequency_i,
  input  wire logic [10:0] table_index_i,
  input  wire logic signed [23:0] table_value_i,
  input  wire logic [31:0] phase_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [23:0] sample_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
`include "assert_macros.svh"

  localparam int DEPTH = (1 << MAX_LOG2_POINTS) + 3;
  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(MAX_LOG2_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_RD, S_K3, S_K2, S_K1, S_HERM, S_F0, S_F1, S_F2, S_F3,
    S_F4, S_ADV, S_AVG, S_OUT
  } state_e;

  // Configuration
  logic [3:0]  log2_q;
  logic [31:0] step_scale_q;
  logic        ready_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= 4'd9;
      step_scale_q <= 32'd1466015503;
      ready_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wosc_pkg::REG_LOG2: log2_q <= pwdata[3:0];
        wosc_pkg::REG_STEP: step_scale_q <= pwdata;
        wosc_pkg::REG_RDY:  ready_q <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      wosc_pkg::REG_LOG2: prdata = {28'd0, log2_q};
      wosc_pkg::REG_STEP: prdata = step_scale_q;
      wosc_pkg::REG_RDY:  prdata = {31'd0, ready_q};
      default: prdata = 32'd0;
    endcase
  end

  // Effective table size
  logic [LW-1:0] lpts;
  always_comb begin
    if (log2_q < 4'd2) lpts = LW'(2);
    else if (32'(log2_q) > MAX_LOG2_POINTS) lpts = LW'(MAX_LOG2_POINTS);
    else lpts = LW'(log2_q);
  end

  // Wavetable memory, one write and one registered read port
  logic signed [23:0] mem [DEPTH];
  logic [AW-1:0] raddr;
  logic signed [23:0] rdata_q;
  logic in_acc;
  logic mem_we;
  assign in_acc = in_valid_i && !in_stall_o;
  assign mem_we = in_acc && cmd_i == wosc_pkg::CMD_WRITE && 32'(table_index_i) < DEPTH;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[AW'(table_index_i)] <= table_value_i;
    rdata_q <= mem[raddr];
  end

  state_e state_q;
  logic [31:0] phase_q, step_q;
  logic [1:0] sub_q;
  logic [2:0] rcnt_q;
  logic [AW-1:0] idx_q;
  logic signed [27:0] x_q, xi1_q, xi2_q, yo1_q, yo2_q;
  logic signed [27:0] ta_q, tb_q, tc_q, td_q;
  logic signed [31:0] t_q;
  logic [22:0] f_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] sum_q;
  logic signed [23:0] frq_q;
  logic signed [23:0] samp_q;
  logic ov_q;

  assign in_stall_o = state_q != S_IDLE || ov_q;
  assign out_valid_o = ov_q;
  assign sample_o = samp_q;
  assign raddr = idx_q + AW'(rcnt_q);

  // Shared multiplier: one product per cycle
  logic signed [31:0] ma;
  logic signed [32:0] mb;
  logic signed [64:0] mp;
  always_comb begin
    ma = '0; mb = '0;
    case (state_q)
      S_STEP: begin ma = 32'(frq_q); mb = {1'b0, step_scale_q}; end
      S_K2, S_K1, S_HERM: begin ma = t_q; mb = {10'd0, f_q}; end
      S_F0: begin ma = 32'(x_q); mb = 33'(wosc_pkg::COEF_B0); end
      S_F1: begin ma = 32'(xi1_q); mb = 33'(wosc_pkg::COEF_B1); end
      S_F2: begin ma = 32'(xi2_q); mb = 33'(wosc_pkg::COEF_B0); end
      S_F3: begin ma = 32'(yo1_q); mb = 33'(wosc_pkg::COEF_A1); end
      S_F4: begin ma = 32'(yo2_q); mb = -33'(wosc_pkg::COEF_A2); end
      default: ;
    endcase
    mp = ma * mb;
  end

  logic signed [31:0] k1, k2, k3;
  logic signed [27:0] yv;
  logic signed [33:0] avg;
  assign k1 = 32'(tc_q) - 32'(ta_q);
  assign k2 = 2*32'(ta_q) - 5*32'(tb_q) + 4*32'(tc_q) - 32'(td_q);
  assign k3 = (32'(td_q) - 32'(ta_q)) + 3*(32'(tb_q) - 32'(tc_q));
  assign yv = wosc_pkg::sat28((acc_q + 64'sd2097152) >>> 22);
  assign avg = (34'(sum_q) + 34'sd2) >>> 2;

  // Final Horner product and halving, into x for the filter
  logic signed [27:0] herm_d;
  logic signed [31:0] t3;
  assign t3 = 32'(mp >>> wosc_pkg::FRAC_BITS);
  assign herm_d = wosc_pkg::sat28(64'((t3 >>> 1) + 32'(tb_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ov_q <= 1'b0; phase_q <= '0;
      xi1_q <= '0; xi2_q <= '0; yo1_q <= '0; yo2_q <= '0;
      sub_q <= '0; rcnt_q <= '0; idx_q <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          frq_q <= frequency_i;
          if (cmd_i == wosc_pkg::CMD_PHASE) phase_q <= phase_value_i;
          if (cmd_i == wosc_pkg::CMD_SAMPLE) begin
            if (!ready_q) begin
              samp_q <= '0; ov_q <= 1'b1;
            end else begin
              state_q <= S_STEP;
            end
          end
        end
        S_STEP: begin
          step_q <= mp[55:24];
          sub_q <= '0; sum_q <= '0;
          idx_q <= AW'(phase_q >> (6'd32 - 6'(lpts)));
          f_q <= 23'((phase_q << lpts) >> 9);
          rcnt_q <= 3'd0;
          state_q <= S_RD;
        end
        S_RD: begin
          // address issued at rcnt, data returns in the next cycle
          rcnt_q <= rcnt_q + 3'd1;
          case (rcnt_q)
            3'd1: ta_q <= 28'(rdata_q);
            3'd2: tb_q <= 28'(rdata_q);
            3'd3: tc_q <= 28'(rdata_q);
            3'd4: td_q <= 28'(rdata_q);
            default: ;
          endcase
          if (rcnt_q == 3'd4) state_q <= S_K3;
        end
        S_K3: begin t_q <= k3; state_q <= S_K2; end
        default: ;
      endcase
      case (state_q)
        S_K3: ;
        S_K2: begin
          t_q <= 32'(mp >>> wosc_pkg::FRAC_BITS) + k2; state_q <= S_K1;
        end
        S_K1: begin
          t_q <= 32'(mp >>> wosc_pkg::FRAC_BITS) + k1; state_q <= S_HERM;
        end
        S_HERM: begin
          // last Horner product reuses the multiplier on t
          x_q <= herm_d; state_q <= S_F0;
        end
        default: ;
      endcase
      case (state_q)
        S_F0: begin acc_q <= 64'(mp); state_q <= S_F1; end
        S_F1: begin acc_q <= acc_q + 64'(mp); state_q <= S_F2; end
        S_F2: begin acc_q <= acc_q + 64'(mp); state_q <= S_F3; end
        S_F3: begin acc_q <= acc_q + 64'(mp); state_q <= S_F4; end
        S_F4: begin acc_q <= acc_q + 64'(mp); state_q <= S_ADV; end
        S_ADV: begin
          xi2_q <= xi1_q; xi1_q <= x_q; yo2_q <= yo1_q; yo1_q <= yv;
          sum_q <= sum_q + 32'(yv);
          phase_q <= phase_q + step_q;
          sub_q <= sub_q + 2'd1;
          if (sub_q == 2'd3) begin
            state_q <= S_AVG;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          idx_q <= AW'(phase_q >> (6'd32 - 6'(lpts)));
          f_q <= 23'((phase_q << lpts) >> 9);
          rcnt_q <= 3'd0;
          state_q <= S_RD;
        end
        S_AVG: begin
          if (avg > 34'sd8388607) samp_q <= 24'sh7fffff;
          else if (avg < -34'sd8388608) samp_q <= 24'sh800000;
          else samp_q <= avg[23:0];
          ov_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_no_accept_busy, clk_i, rst_ni,
    (state_q != S_IDLE) |-> in_stall_o, "accept while busy")
  `ASSERT_CLK(a_out_once, clk_i, rst_ni,
    (state_q == S_AVG) |=> out_valid_o, "result not raised")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_o)), "result dropped")
  `ASSERT_NEVER(a_out_while_busy, clk_i, rst_ni,
    out_valid_o && state_q != S_IDLE, "result raised while busy")
endmodule
`default_nettype wire

// File: test/tb_wavetable_osc_hermite_oversampled.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_wavetable_osc_hermite_oversampled;

  localparam int TBL_DEPTH = 1027;
  // entries read with up to 512 points
  localparam int LOAD_DEPTH = 515;
  localparam longint B0 = 253041;
  localparam longint B1 = 506081;
  localparam longint A1 = 4850713;
  localparam longint A2 = 1668565;

  // Golden oscillator and expected-sample store
  class osc_scoreboard;
    bit [3:0]  log2_pts;
    bit [31:0] step_k;
    bit        ready;
    bit [31:0] phase;
    longint    wtab [TBL_DEPTH];
    longint    x1, x2, y1, y2;
    logic signed [23:0] pending_samples [$];
    int        errors;

    function void clear();
      log2_pts = 9; step_k = 32'd1466015503; ready = 0; phase = 0;
      x1 = 0; x2 = 0; y1 = 0; y2 = 0; errors = 0;
      foreach (wtab[i]) wtab[i] = 0;
    endfunction

    function longint fshr(longint v, int s);
      return v >>> s;
    endfunction

    function longint clip(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint rd(int unsigned i);
      return i < TBL_DEPTH ? wtab[i] : 0;
    endfunction

    function longint interp(int unsigned i, longint f);
      longint a, b, c, d, k1, k2, k3, t;
      a = rd(i); b = rd(i + 1); c = rd(i + 2); d = rd(i + 3);
      k1 = c - a;
      k2 = 2 * a - 5 * b + 4 * c - d;
      k3 = (d - a) + 3 * (b - c);
      t = fshr(k3 * f, 23) + k2;
      t = fshr(t * f, 23) + k1;
      t = fshr(t * f, 23);
      return clip(fshr(t, 1) + b, 28);
    endfunction

    function longint lowpass(longint x);
      longint acc, y;
      acc = B0 * x + B1 * x1 + B0 * x2 + A1 * y1 - A2 * y2;
      y = clip(fshr(acc + (longint'(1) << 21), 22), 28);
      x2 = x1; x1 = x; y2 = y1; y1 = y;
      return y;
    endfunction

    function void cfg_write(logic [1:0] idx, logic [31:0] v);
      case (idx)
        wosc_pkg::REG_LOG2: log2_pts = v[3:0];
        wosc_pkg::REG_STEP: step_k = v;
        wosc_pkg::REG_RDY:  ready = v[0];
        default: ;
      endcase
    endfunction

    // Note one accepted command
    function void note_command(wosc_pkg::cmd_e c, logic signed [23:0] fr,
                               logic [10:0] ti, logic signed [23:0] tv,
                               logic [31:0] pv);
      int unsigned l, idx;
      longint sum, fq, f;
      bit [31:0] stp, sh;
      bit [63:0] prod;
      case (c)
        wosc_pkg::CMD_WRITE: if (ti < TBL_DEPTH) wtab[ti] = tv;
        wosc_pkg::CMD_PHASE: phase = pv;
        wosc_pkg::CMD_SAMPLE: begin
          if (!ready) begin
            pending_samples.push_back(24'sd0);
          end else begin
            l = log2_pts < 2 ? 2 : (log2_pts > 10 ? 10 : log2_pts);
            fq = fr;
            prod = fq * longint'(step_k);
            stp = prod[55:24];
            sum = 0;
            for (int k = 0; k < 4; k++) begin
              idx = phase >> (32 - l);
              sh = phase << l;
              f = longint'(sh >> 9);
              sum += lowpass(interp(idx, f));
              phase += stp;
            end
            pending_samples.push_back(24'(clip(fshr(sum + 2, 2), 24)));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_sample(logic signed [23:0] got);
      logic signed [23:0] want;
      if (pending_samples.size() == 0) begin
        $error("sample: unexpected transaction, actual %0d", got);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      if (got !== want) begin
        $error("sample: expected %0d actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [1:0] cmd_i = '0;
  logic signed [23:0] frequency_i = '0, table_value_i = '0;
  logic [10:0] table_index_i = '0;
  logic [31:0] phase_value_i = '0;
  wire in_stall_o, out_valid_o, pready;
  wire signed [23:0] sample_o;
  wire [31:0] prdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;

  osc_scoreboard sb = new();
  int idle_pct = 34;
  int hold_cycles = 0;

  wavetable_osc_hermite_oversampled dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // Receiver stall pattern, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_sample(sample_o);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    in_valid_i <= 0;
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.cfg_write(idx, v);
  endtask

  // Called at a rising edge; leaves valid high for a following transaction
  task automatic send(wosc_pkg::cmd_e c, logic signed [23:0] fr, logic [10:0] ti,
                      logic signed [23:0] tv, logic [31:0] pv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; cmd_i <= c; frequency_i <= fr;
    table_index_i <= ti; table_value_i <= tv; phase_value_i <= pv;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c, fr, ti, tv, pv);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic sample_cmd(logic signed [23:0] fr);
    send(wosc_pkg::CMD_SAMPLE, fr, 11'($urandom), 24'($urandom), $urandom);
  endtask

  // Fill every entry that up to 512 points can read
  task automatic load_table();
    for (int i = 0; i < LOAD_DEPTH; i++)
      send(wosc_pkg::CMD_WRITE, '0, 11'(i), 24'($urandom), $urandom);
  endtask

  task automatic rand_command();
    int r;
    r = $urandom_range(99);
    if (r < 75) sample_cmd($urandom_range(3) == 0 ? 24'($urandom)
                           : 24'($signed($urandom_range(200000)) - 100000));
    else if (r < 85) send(wosc_pkg::CMD_WRITE, 24'($urandom), 11'($urandom_range(1100)),
                          24'($urandom), $urandom);
    else if (r < 95) send(wosc_pkg::CMD_PHASE, 24'($urandom), 11'($urandom),
                          24'($urandom), $urandom);
    else send(wosc_pkg::CMD_NONE, 24'($urandom), 11'($urandom), 24'($urandom), $urandom);
  endtask

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // Not ready: zero output, phase frozen
    sample_cmd(24'sd8388607);
    sample_cmd(-24'sd8388608);
    send(wosc_pkg::CMD_NONE, '0, '0, '0, '0);
    load_table();
    send(wosc_pkg::CMD_WRITE, '0, 11'd1026, -24'sd8388608, '0);
    send(wosc_pkg::CMD_WRITE, '0, 11'd1027, 24'sd8388607, '0);
    send(wosc_pkg::CMD_WRITE, '0, 11'd2047, 24'sd1, '0);
    drain();
    reg_write(wosc_pkg::REG_RDY, 32'd1);
    sample_cmd(24'sd8388607);
    sample_cmd(-24'sd8388608);
    sample_cmd('0);
    send(wosc_pkg::CMD_PHASE, '0, '0, '0, 32'hffff_ffff);
    sample_cmd(24'sd440 <<< 8);
    send(wosc_pkg::CMD_PHASE, '0, '0, '0, 32'h0);
    sample_cmd(-24'sd1);
    drain();
    // Clamped sizes
    reg_write(wosc_pkg::REG_LOG2, 32'd0);
    reg_write(wosc_pkg::REG_STEP, 32'hffff_ffff);
    sample_cmd(24'sd8388607);
    sample_cmd(-24'sd8388608);
    drain();
    // Largest size at a frozen phase of zero
    reg_write(wosc_pkg::REG_LOG2, 32'd15);
    reg_write(wosc_pkg::REG_STEP, 32'd0);
    send(wosc_pkg::CMD_PHASE, '0, '0, '0, 32'h0);
    sample_cmd(24'sd12345);
    drain();
    reg_write(wosc_pkg::REG_LOG2, 32'd9);
    reg_write(wosc_pkg::REG_STEP, 32'd1466015503);

    // Random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      idle_pct = (ph == 2) ? 0 : 34;
      for (int n = 0; n < 48; n++) begin
        if (ph == 3 && n == 10) hold_cycles = 400;
        if (n == 24) drain();
        rand_command();
      end
      drain();
      case (ph)
        0: begin reg_write(wosc_pkg::REG_LOG2, 32'd2);
                 reg_write(wosc_pkg::REG_STEP, $urandom); end
        1: begin reg_write(wosc_pkg::REG_LOG2, 32'($urandom_range(9, 2)));
                 reg_write(wosc_pkg::REG_STEP, 32'd0); end
        2: begin reg_write(wosc_pkg::REG_RDY, 32'd0); end
        3: begin reg_write(wosc_pkg::REG_RDY, 32'd1); reg_write(wosc_pkg::REG_LOG2, 32'd9);
                 reg_write(wosc_pkg::REG_STEP, 32'hffff_ffff); end
        default: ;
      endcase
    end
    drain();
    if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
